FILE: design/i2p_pkg.sv
// Package: token types, codes and constants for the infix to postfix converter.
`timescale 1ns / 1ps

package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [2:0] MODE_OPERAND = 3'd0;
  localparam logic [2:0] MODE_OPEN    = 3'd1;
  localparam logic [2:0] MODE_CLOSE   = 3'd2;
  localparam logic [2:0] MODE_OPER    = 3'd3;
  localparam logic [2:0] MODE_END     = 3'd4;

  localparam logic [2:0] PAREN_CODE = 3'd4;

  localparam logic [1:0] KIND_OPERAND  = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNMATCH  = 2'd2;
  localparam logic [1:0] ERR_UNCLOSED = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  op_code;
    logic [31:0] operand_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [1:0]  out_op;
    logic [31:0] out_value;
    logic [1:0]  error_code;
    logic        last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_END_MARK,
    ST_FLUSH
  } state_t;

  function automatic out_t make_res(input logic [1:0] kind, input logic [1:0] op,
                                    input logic [31:0] value, input logic [1:0] err);
    out_t r;
    r.out_kind   = kind;
    r.out_op     = op;
    r.out_value  = value;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  // stacked operator pops before incoming one when its priority is not lower
  function automatic logic pops_first(input logic [1:0] stacked, input logic [1:0] incoming);
    return stacked[1] | ~incoming[1];
  endfunction

endpackage

FILE: design/i2p_stack.sv
// Operator stack memory: one write port, one registered read port with write forwarding.
`timescale 1ns / 1ps

module i2p_stack #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [2:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [2:0]               rdata
);

  logic [2:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/i2p_out_stage.sv
// Output register: holds one result transaction until the sink takes it.
`timescale 1ns / 1ps

module i2p_out_stage (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  i2p_pkg::out_t item,
  output logic         free,
  output logic         res_valid,
  input  logic         res_stall,
  output i2p_pkg::out_t res
);

  import i2p_pkg::*;

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= item;
    end
  end

endmodule

FILE: design/i2p_ctrl.sv
// Sequencer: accepts tokens, pops and pushes the stack, marks the final result.
`timescale 1ns / 1ps

module i2p_ctrl #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tok_valid,
  output logic                           tok_stall,
  input  i2p_pkg::in_t                   tok,
  input  logic                           out_free,
  output logic                           out_load,
  output i2p_pkg::out_t                  out_item,
  output logic                           mem_we,
  output logic [$clog2(STACK_DEPTH)-1:0] mem_waddr,
  output logic [2:0]                     mem_wdata,
  output logic [$clog2(STACK_DEPTH)-1:0] mem_raddr,
  input  logic [2:0]                     mem_rdata
);

  import i2p_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
  localparam logic [31:0] VALUE_MASK =
      (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << VALUE_WIDTH) - 32'd1);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [2:0]    held_mode;
  logic [1:0]    held_code;
  logic          paren_seen;
  logic          pend_valid;
  out_t          pend;

  logic          accept, ne, full, top_paren, step;
  logic          gen, direct, flush_emit, hold_tok, paren_set;
  out_t          gen_item, direct_item;

  assign accept    = tok_valid && (state == ST_IDLE) && out_free;
  assign tok_stall = !((state == ST_IDLE) && out_free);
  assign ne        = (count != '0);
  assign full      = (count == FULL_COUNT);
  assign top_paren = (mem_rdata == PAREN_CODE);
  assign step      = out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (tok.mode inside {MODE_CLOSE, MODE_OPER, MODE_END})) begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (step) begin
          case (held_mode)
            MODE_CLOSE: if (!(ne && !top_paren)) state_next = ST_FLUSH;
            MODE_OPER: begin
              if (!(ne && !top_paren && pops_first(mem_rdata[1:0], held_code))) begin
                state_next = ST_FLUSH;
              end
            end
            default: if (!ne) state_next = paren_seen ? ST_END_MARK : ST_FLUSH;
          endcase
        end
      end
      ST_END_MARK: if (step) state_next = ST_FLUSH;
      ST_FLUSH: if (!pend_valid || out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    gen         = 1'b0;
    gen_item    = make_res(KIND_OPERAND, 2'd0, 32'd0, ERR_NONE);
    direct      = 1'b0;
    direct_item = make_res(KIND_OPERAND, 2'd0, 32'd0, ERR_NONE);
    flush_emit  = 1'b0;
    hold_tok    = 1'b0;
    paren_set   = 1'b0;
    count_next  = count;
    mem_we      = 1'b0;
    mem_waddr   = count[AW-1:0];
    mem_wdata   = PAREN_CODE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (tok.mode)
            MODE_OPERAND: begin
              direct      = 1'b1;
              direct_item = make_res(KIND_OPERAND, 2'd0, tok.operand_value & VALUE_MASK,
                                     ERR_NONE);
            end
            MODE_OPEN: begin
              if (full) begin
                direct      = 1'b1;
                direct_item = make_res(KIND_ERROR, 2'd0, 32'd0, ERR_OVERFLOW);
              end else begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            MODE_CLOSE, MODE_OPER, MODE_END: hold_tok = 1'b1;
            default: ;
          endcase
        end
      end
      ST_POP: begin
        if (step) begin
          case (held_mode)
            MODE_CLOSE: begin
              if (ne && !top_paren) begin
                gen        = 1'b1;
                gen_item   = make_res(KIND_OPERATOR, mem_rdata[1:0], 32'd0, ERR_NONE);
                count_next = count - 1'b1;
              end else if (ne) begin
                count_next = count - 1'b1;
              end else begin
                gen      = 1'b1;
                gen_item = make_res(KIND_ERROR, 2'd0, 32'd0, ERR_UNMATCH);
              end
            end
            MODE_OPER: begin
              if (ne && !top_paren && pops_first(mem_rdata[1:0], held_code)) begin
                gen        = 1'b1;
                gen_item   = make_res(KIND_OPERATOR, mem_rdata[1:0], 32'd0, ERR_NONE);
                count_next = count - 1'b1;
              end else if (full) begin
                gen      = 1'b1;
                gen_item = make_res(KIND_ERROR, 2'd0, 32'd0, ERR_OVERFLOW);
              end else begin
                mem_we     = 1'b1;
                mem_wdata  = {1'b0, held_code};
                count_next = count + 1'b1;
              end
            end
            default: begin
              if (ne) begin
                count_next = count - 1'b1;
                if (top_paren) begin
                  paren_set = 1'b1;
                end else begin
                  gen      = 1'b1;
                  gen_item = make_res(KIND_OPERATOR, mem_rdata[1:0], 32'd0, ERR_NONE);
                end
              end else if (paren_seen) begin
                gen      = 1'b1;
                gen_item = make_res(KIND_ERROR, 2'd0, 32'd0, ERR_UNCLOSED);
              end else begin
                gen      = 1'b1;
                gen_item = make_res(KIND_END, 2'd0, 32'd0, ERR_NONE);
              end
            end
          endcase
        end
      end
      ST_END_MARK: begin
        if (step) begin
          gen      = 1'b1;
          gen_item = make_res(KIND_END, 2'd0, 32'd0, ERR_NONE);
        end
      end
      ST_FLUSH: flush_emit = pend_valid && out_free;
      default: ;
    endcase
  end

  assign mem_raddr = AW'(count_next - 1'b1);

  always_comb begin
    out_load = direct || (gen && pend_valid) || flush_emit;
    if (direct) begin
      out_item      = direct_item;
      out_item.last = 1'b1;
    end else begin
      out_item      = pend;
      out_item.last = flush_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      paren_seen <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (gen) begin
        pend_valid <= 1'b1;
      end else if (flush_emit) begin
        pend_valid <= 1'b0;
      end
      if (hold_tok) begin
        paren_seen <= 1'b0;
      end else if (paren_set) begin
        paren_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_tok) begin
      held_mode <= tok.mode;
      held_code <= tok.op_code;
    end
    if (gen) begin
      pend <= gen_item;
    end
  end

endmodule

FILE: design/infix_to_postfix_converter.sv
// Top level: infix token stream in, postfix token stream out, shunting-yard order.
// An operand or a full-stack open paren shows its result in the cycle after accept.
// Operand and open paren are done at accept; close paren, operator and end stall tokens
// while stack entries are popped, a close paren dropping its open paren in the last pop
// (end with a stray paren adds an end-mark step); one stack read per cycle when out is free.
// Reset: synchronous; empties the stack count and output register, memory is not cleared.
`timescale 1ns / 1ps

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = i2p_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  output logic          tok_stall,
  input  i2p_pkg::in_t  tok,
  output logic          res_valid,
  input  logic          res_stall,
  output i2p_pkg::out_t res
);

  import i2p_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  logic          out_free, out_load;
  out_t          out_item;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [2:0]    mem_wdata, mem_rdata;

  i2p_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  i2p_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  i2p_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .item      (out_item),
    .free      (out_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

FILE: dv/infix_to_postfix_converter_tb.sv
// Testbench for the infix to postfix converter: token driver, postfix predictor and checker.
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int STACK_SLOTS    = STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 60;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int HOLDOFF_AFTER  = 30;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic [1:0] OP_PLUS   = 2'd0;
  localparam logic [1:0] OP_MINUS  = 2'd1;
  localparam logic [1:0] OP_TIMES  = 2'd2;
  localparam logic [1:0] OP_DIVIDE = 2'd3;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  tok_valid = 1'b0;
  logic  tok_stall;
  in_t   tok       = '0;
  logic  res_valid;
  logic  res_stall = 1'b0;
  out_t  res;

  in_t        tok_q[$];
  out_t       postfix_q[$];
  logic [2:0] op_stk[STACK_SLOTS];
  int         stk_cnt;
  int         errors       = 0;
  int         stim_items   = 0;
  int         send_wait    = 0;
  int         rcv_wait     = 0;
  int         results_seen = 0;
  int         idle_cycles  = 0;
  bit         send_quiet   = 1'b0;
  bit         rcv_quiet    = 1'b0;
  bit         held_off     = 1'b0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH_DEF),
    .VALUE_WIDTH(VALUE_WIDTH_DEF)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #1 clk = ~clk;

  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 19) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int op_rank(input logic [1:0] code);
    return (code == OP_TIMES || code == OP_DIVIDE) ? 2 : 1;
  endfunction

  function automatic out_t postfix_tok(input logic [1:0] kind, input logic [1:0] op,
                                       input logic [31:0] value, input logic [1:0] err);
    out_t r;
    r.out_kind   = kind;
    r.out_op     = op;
    r.out_value  = value;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  // Run one token through the shunting-yard stack and queue the postfix tokens it releases.
  function automatic void predict_postfix(input in_t t);
    out_t       rel[$];
    logic [2:0] top;
    bit         paren_seen;
    paren_seen = 1'b0;
    case (t.mode)
      MODE_OPERAND: begin
        rel = {rel, postfix_tok(KIND_OPERAND, 2'd0, t.operand_value, ERR_NONE)};
      end
      MODE_OPEN: begin
        if (stk_cnt >= STACK_SLOTS) begin
          rel = {rel, postfix_tok(KIND_ERROR, 2'd0, '0, ERR_OVERFLOW)};
        end else begin
          op_stk[stk_cnt] = PAREN_CODE;
          stk_cnt++;
        end
      end
      MODE_CLOSE: begin
        while (stk_cnt > 0 && op_stk[stk_cnt-1] != PAREN_CODE) begin
          rel = {rel, postfix_tok(KIND_OPERATOR, op_stk[stk_cnt-1][1:0], '0, ERR_NONE)};
          stk_cnt--;
        end
        if (stk_cnt > 0) stk_cnt--;
        else rel = {rel, postfix_tok(KIND_ERROR, 2'd0, '0, ERR_UNMATCH)};
      end
      MODE_OPER: begin
        while (stk_cnt > 0) begin
          top = op_stk[stk_cnt-1];
          if (top == PAREN_CODE || op_rank(top[1:0]) < op_rank(t.op_code)) break;
          rel = {rel, postfix_tok(KIND_OPERATOR, top[1:0], '0, ERR_NONE)};
          stk_cnt--;
        end
        if (stk_cnt >= STACK_SLOTS) begin
          rel = {rel, postfix_tok(KIND_ERROR, 2'd0, '0, ERR_OVERFLOW)};
        end else begin
          op_stk[stk_cnt] = {1'b0, t.op_code};
          stk_cnt++;
        end
      end
      MODE_END: begin
        while (stk_cnt > 0) begin
          top = op_stk[stk_cnt-1];
          if (top == PAREN_CODE) paren_seen = 1'b1;
          else rel = {rel, postfix_tok(KIND_OPERATOR, top[1:0], '0, ERR_NONE)};
          stk_cnt--;
        end
        if (paren_seen) rel = {rel, postfix_tok(KIND_ERROR, 2'd0, '0, ERR_UNCLOSED)};
        rel = {rel, postfix_tok(KIND_END, 2'd0, '0, ERR_NONE)};
      end
      default: ;
    endcase
    if (rel.size() > 0) rel[rel.size()-1].last = 1'b1;
    postfix_q = {postfix_q, rel};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  task automatic push_tok(input logic [2:0] mode, input logic [1:0] op,
                          input logic [31:0] value);
    in_t t;
    t.mode          = mode;
    t.op_code       = op;
    t.operand_value = value;
    tok_q = {tok_q, t};
    if (mode <= MODE_END) stim_items++;
  endtask

  task automatic gen_term(input int lvl);
    if (lvl < 3 && $urandom_range(0, 3) == 0) begin
      push_tok(MODE_OPEN, 2'($urandom), $urandom);
      gen_expr(lvl + 1);
      push_tok(MODE_CLOSE, 2'($urandom), $urandom);
    end else begin
      push_tok(MODE_OPERAND, 2'($urandom), rand_word());
    end
  endtask

  task automatic gen_expr(input int lvl);
    int terms;
    terms = $urandom_range(0, 3);
    gen_term(lvl);
    repeat (terms) begin
      push_tok(MODE_OPER, 2'($urandom), $urandom);
      gen_term(lvl);
    end
  endtask

  // Nest deep enough to run the operator stack into its limit.
  task automatic gen_flood(input int paren_pct);
    int n;
    n = $urandom_range(STACK_SLOTS, STACK_SLOTS + 4);
    repeat (n) begin
      if ($urandom_range(0, 99) < paren_pct) push_tok(MODE_OPEN, 2'($urandom), $urandom);
      else push_tok(MODE_OPER, 2'($urandom_range(OP_PLUS, OP_MINUS)), $urandom);
    end
    push_tok(MODE_OPER, 2'($urandom), $urandom);
    push_tok(MODE_OPEN, 2'($urandom), $urandom);
    push_tok(MODE_OPERAND, 2'($urandom), rand_word());
    push_tok(MODE_END, 2'($urandom), $urandom);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      send_wait = 0;
    end else if (!tok_valid || !tok_stall) begin
      if (send_wait > 0) begin
        send_wait--;
        tok_valid <= 1'b0;
      end else if (tok_q.size() > 0) begin
        tok       <= tok_q.pop_front();
        tok_valid <= 1'b1;
        send_wait = draw_gap(send_quiet);
      end else begin
        tok_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      stk_cnt = 0;
      rcv_wait = 0;
      res_stall <= 1'b0;
    end else begin
      if (tok_valid && !tok_stall) predict_postfix(tok);
      if (res_valid && !res_stall) begin
        results_seen++;
        if (postfix_q.size() == 0) begin
          $error("unexpected result: out_kind %0d, out_value %0h", res.out_kind, res.out_value);
          errors++;
        end else begin
          want = postfix_q.pop_front();
          check_field("out_kind", 32'(want.out_kind), 32'(res.out_kind));
          check_field("out_op", 32'(want.out_op), 32'(res.out_op));
          check_field("out_value", want.out_value, res.out_value);
          check_field("error_code", 32'(want.error_code), 32'(res.error_code));
          check_field("last", 32'(want.last), 32'(res.last));
        end
        rcv_wait = draw_gap(rcv_quiet);
        if (!held_off && results_seen == HOLDOFF_AFTER) begin
          rcv_wait = HOLDOFF_CYCLES;
          held_off = 1'b1;
        end
      end else if (rcv_wait > 0) begin
        rcv_wait--;
      end
      res_stall <= (rcv_wait > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (tok_valid && !tok_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int random_start;
    int pick;

    push_tok(MODE_OPERAND, OP_DIVIDE, 32'h0000_0000);
    push_tok(MODE_OPER, OP_PLUS, 32'hFFFF_FFFF);
    push_tok(MODE_OPERAND, OP_TIMES, 32'hFFFF_FFFF);
    push_tok(MODE_OPER, OP_TIMES, 32'h0);
    push_tok(MODE_OPERAND, OP_PLUS, 32'h7);
    push_tok(MODE_OPER, OP_MINUS, 32'h0);
    push_tok(MODE_OPERAND, OP_MINUS, 32'h8000_0001);
    push_tok(MODE_OPER, OP_DIVIDE, 32'h0);
    push_tok(MODE_OPERAND, OP_PLUS, 32'h2);
    push_tok(MODE_END, OP_DIVIDE, 32'hFFFF_FFFF);
    push_tok(MODE_OPEN, OP_PLUS, 32'h0);
    push_tok(MODE_OPERAND, OP_PLUS, 32'h1234_5678);
    push_tok(MODE_OPER, OP_PLUS, 32'h0);
    push_tok(MODE_OPERAND, OP_PLUS, 32'h5555_AAAA);
    push_tok(MODE_CLOSE, OP_PLUS, 32'h0);
    push_tok(MODE_OPER, OP_TIMES, 32'h0);
    push_tok(MODE_OPERAND, OP_PLUS, 32'hAAAA_5555);
    push_tok(MODE_CLOSE, OP_PLUS, 32'h0);
    push_tok(MODE_OPEN, OP_PLUS, 32'h0);
    push_tok(MODE_END, OP_PLUS, 32'h0);
    push_tok(3'd5, OP_TIMES, $urandom);
    push_tok(3'd6, OP_MINUS, $urandom);
    push_tok(3'd7, OP_DIVIDE, $urandom);

    random_start = stim_items;
    gen_flood(100);
    while (stim_items - random_start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        gen_expr(0);
      end else if (pick == 6) begin
        gen_flood(75);
        continue;
      end else if (pick <= 8) begin
        repeat ($urandom_range(2, 8)) begin
          push_tok(3'($urandom_range(0, 7)), 2'($urandom), rand_word());
        end
      end else begin
        if ($urandom_range(0, 1)) push_tok(MODE_OPEN, 2'($urandom), $urandom);
        gen_expr(0);
        if ($urandom_range(0, 1)) push_tok(MODE_CLOSE, 2'($urandom), $urandom);
        else push_tok(MODE_OPER, 2'($urandom), $urandom);
      end
      push_tok(MODE_END, 2'($urandom), $urandom);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (tok_q.size() != 0 || tok_valid || postfix_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
